// ===== design/version_string_parser_macros.svh =====
// Assertion macros for the version string parser.
`ifndef VERSION_STRING_PARSER_MACROS_SVH
`define VERSION_STRING_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VSP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define VSP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");
`else
`define VSP_ASSERT(label, prop)
`define VSP_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== design/vsp_pkg.sv =====
package vsp_pkg;

   localparam int NUM_W = 10;
   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;

   typedef enum logic [7:0] {
      PH_MAJ_FIRST = 8'b0000_0001,
      PH_MAJ_MORE  = 8'b0000_0010,
      PH_MIN_FIRST = 8'b0000_0100,
      PH_MIN_MORE  = 8'b0000_1000,
      PH_PT_FIRST  = 8'b0001_0000,
      PH_PT_MORE   = 8'b0010_0000,
      PH_REV_FIRST = 8'b0100_0000,
      PH_REV_MORE  = 8'b1000_0000
   } phase_type;

   localparam logic [KIND_W-1:0] KIND_DEV     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BETA    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_BETA   = 8'h62;
   localparam logic [CHAR_W-1:0] CH_DEV    = 8'h64;

endpackage

// ===== design/version_string_parser.sv =====
// The result for a string is on rsp_tvalid in the cycle after its NUL byte is taken.
// Throughput: one byte per cycle while req_tready is high; a single-step state update
// per byte, multiply by ten done as shift-and-add ahead of the state registers.
// A stalled result blocks further input only while the output register stays full.
// Reset (synchronous, active high) returns the parser to the start of a string
// and empties the output register.
`include "version_string_parser_macros.svh"

module version_string_parser #(
   parameter int NUMBER_LIMIT = 1000
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [vsp_pkg::CHAR_W-1:0]    req_tdata,   // ch
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [4*vsp_pkg::NUM_W-1:0]   rsp_tdata,   // major_num, minor_num, point_num,
                                                      // revision_num
   output logic [vsp_pkg::KIND_W:0]      rsp_tuser    // valid_res, kind
);
   import vsp_pkg::*;

   localparam int ACC_RAW_W = $clog2(NUMBER_LIMIT * 10);
   localparam int ACC_W = (ACC_RAW_W > NUM_W) ? ACC_RAW_W : NUM_W;

   phase_type         phase_ff, phase_in;
   logic [ACC_W-1:0]  accum_ff, accum_in;
   logic              lead_zero_ff, lead_zero_in;
   logic              failed_ff, failed_in;
   logic [NUM_W-1:0]  major_ff, major_in;
   logic [NUM_W-1:0]  minor_ff, minor_in;
   logic [NUM_W-1:0]  point_ff, point_in;
   logic [KIND_W-1:0] kind_ff, kind_in;

   logic              out_valid_ff;
   logic              res_valid_ff, res_valid_in;
   logic [KIND_W-1:0] res_kind_ff, res_kind_in;
   logic [NUM_W-1:0]  res_major_ff, res_major_in;
   logic [NUM_W-1:0]  res_minor_ff, res_minor_in;
   logic [NUM_W-1:0]  res_point_ff, res_point_in;
   logic [NUM_W-1:0]  res_rev_ff, res_rev_in;

   logic              accept;
   logic              is_nul;
   logic              is_digit;
   logic [3:0]        digit;
   logic [ACC_W-1:0]  accum_grow;
   logic              ok;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_nul     = (req_tdata == CH_NUL);
   assign is_digit   = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign digit      = is_digit ? 4'(req_tdata - CH_ZERO) : 4'd0;
   assign accum_grow = ACC_W'((accum_ff << 3) + (accum_ff << 1) + ACC_W'(digit));

   always_comb begin
      phase_in     = phase_ff;
      accum_in     = accum_ff;
      lead_zero_in = lead_zero_ff;
      failed_in    = failed_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      point_in     = point_ff;
      kind_in      = kind_ff;
      if (is_nul) begin
         phase_in     = PH_MAJ_FIRST;
         accum_in     = '0;
         lead_zero_in = 1'b0;
         failed_in    = 1'b0;
         major_in     = '0;
         minor_in     = '0;
         point_in     = '0;
         kind_in      = KIND_DEV;
      end else if (!failed_ff) begin
         unique case (phase_ff)
            PH_MAJ_FIRST, PH_PT_FIRST, PH_REV_FIRST: begin
               if (is_digit && digit != 4'd0) begin
                  accum_in     = ACC_W'(digit);
                  lead_zero_in = 1'b0;
                  phase_in     = phase_type'(phase_ff << 1);
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_MIN_FIRST: begin
               if (is_digit) begin
                  accum_in     = ACC_W'(digit);
                  lead_zero_in = (digit == 4'd0);
                  phase_in     = PH_MIN_MORE;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_MAJ_MORE, PH_MIN_MORE, PH_PT_MORE, PH_REV_MORE: begin
               if (is_digit) begin
                  if (lead_zero_ff) begin
                     failed_in = 1'b1;
                  end else begin
                     accum_in = accum_grow;
                     if (accum_grow >= ACC_W'(NUMBER_LIMIT)) begin
                        failed_in = 1'b1;
                     end
                  end
               end else if (req_tdata == CH_PERIOD && phase_ff == PH_MAJ_MORE) begin
                  major_in = accum_ff[NUM_W-1:0];
                  accum_in = '0;
                  phase_in = PH_MIN_FIRST;
               end else if (req_tdata == CH_PERIOD && phase_ff == PH_MIN_MORE) begin
                  minor_in     = accum_ff[NUM_W-1:0];
                  accum_in     = '0;
                  lead_zero_in = 1'b0;
                  phase_in     = PH_PT_FIRST;
               end else if ((req_tdata == CH_BETA || req_tdata == CH_DEV) &&
                            (phase_ff == PH_MIN_MORE || phase_ff == PH_PT_MORE)) begin
                  if (phase_ff == PH_MIN_MORE) begin
                     minor_in = accum_ff[NUM_W-1:0];
                     point_in = '0;
                  end else begin
                     point_in = accum_ff[NUM_W-1:0];
                  end
                  kind_in      = (req_tdata == CH_BETA) ? KIND_BETA : KIND_DEV;
                  accum_in     = '0;
                  lead_zero_in = 1'b0;
                  phase_in     = PH_REV_FIRST;
               end else begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      ok           = !failed_ff && (phase_ff == PH_MIN_MORE || phase_ff == PH_PT_MORE ||
                                    phase_ff == PH_REV_MORE);
      res_valid_in = ok;
      res_kind_in  = KIND_DEV;
      res_major_in = '0;
      res_minor_in = '0;
      res_point_in = '0;
      res_rev_in   = '0;
      if (ok) begin
         res_major_in = major_ff;
         res_kind_in  = KIND_RELEASE;
         res_minor_in = minor_ff;
         res_point_in = point_ff;
         if (phase_ff == PH_MIN_MORE) begin
            res_minor_in = accum_ff[NUM_W-1:0];
            res_point_in = '0;
         end else if (phase_ff == PH_PT_MORE) begin
            res_point_in = accum_ff[NUM_W-1:0];
         end else begin
            res_kind_in = kind_ff;
            res_rev_in  = accum_ff[NUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAJ_FIRST;
         failed_ff    <= 1'b0;
         lead_zero_ff <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         failed_ff    <= failed_in;
         lead_zero_ff <= lead_zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         accum_ff <= accum_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         point_ff <= point_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept && is_nul) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_nul) begin
         res_valid_ff <= res_valid_in;
         res_kind_ff  <= res_kind_in;
         res_major_ff <= res_major_in;
         res_minor_ff <= res_minor_in;
         res_point_ff <= res_point_in;
         res_rev_ff   <= res_rev_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_rev_ff, res_point_ff, res_minor_ff, res_major_ff};
   assign rsp_tuser  = {res_kind_ff, res_valid_ff};

   `VSP_ASSERT(a_nul_gives_result, (accept && is_nul) |=> rsp_tvalid)
   `VSP_ASSERT(a_no_spurious_result, (!rsp_tvalid && !(accept && is_nul)) |=> !rsp_tvalid)
   `VSP_ASSERT(a_invalid_is_zero, (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0 && rsp_tuser[KIND_W:1] == KIND_DEV))
   `VSP_ASSERT(a_kind_in_range, rsp_tvalid |-> (rsp_tuser[KIND_W:1] != KIND_UNUSED))
   `VSP_ASSERT_ALWAYS(a_ready_when_empty, !rsp_tvalid |-> req_tready)

endmodule
